[rtl/core/pra_pkg.sv]
// Package for the page run allocator: pool geometry, page map entry layout,
// request and status codes. Depends on nothing.
package pra_pkg;

    localparam int NUM_PAGES  = 64;
    localparam int PAGE_BYTES = 4096;

    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int PG_W       = $clog2(NUM_PAGES);
    localparam int CNT_W      = $clog2(NUM_PAGES + 1);
    localparam int SIZE_W     = 19;
    localparam int OFF_W      = 18;
    localparam int STATUS_W   = 2;

    localparam int unsigned POOL_BYTES = NUM_PAGES * PAGE_BYTES;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NO_SPACE    = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_RANGE       = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_UNSUPPORTED = 2'd3;

    typedef struct packed {
        logic            used;
        logic [PG_W-1:0] run_start;
    } page_entry_t;

    localparam int ENTRY_W = $bits(page_entry_t);

endpackage

[rtl/core/pra_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered
// read data. Depends on nothing.
module pra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[rtl/core/page_run_allocator.sv]
// First-fit page run allocator over a pool of NUM_PAGES pages.
// Request channel: req_valid/req_stall with req_type, size_bytes, free_offset.
// A beat with req_type clear allocates a run of ceil(size_bytes/PAGE_BYTES)
// pages; a beat with req_type set frees the run tagged at free_offset.
// Response channel: rsp_valid/rsp_stall with status and run_offset; every
// request beat yields exactly one response beat, in order.
// One request is worked on at a time; req_stall is high from the accept until
// the result has been moved into the response register.
// Requests rejected by their fields go straight to the response register. An
// allocate scans from page 0 until a window of need pages is found or the last
// page is judged; a free scans from its page while the run tag matches. The
// page map memory is read one page per cycle (pipelined against its registered
// read) and written one page per cycle when a run is tagged.
// A stalled response waits in the output register while the next request is
// already accepted; that request finishes only once the register is free.
// Reset clears the per-page valid bits at once, so every page reads as free
// right after reset and no clearing pass is needed.
module page_run_allocator (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  logic                           req_type,
    input  logic [pra_pkg::SIZE_W-1:0]     size_bytes,
    input  logic [pra_pkg::SIZE_W-1:0]     free_offset,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output logic [pra_pkg::STATUS_W-1:0]   status,
    output logic [pra_pkg::OFF_W-1:0]      run_offset
);

    import pra_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_FILL = 4'b0100,
        S_RESP = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic                  kind_reg, kind_next;
    logic [CNT_W-1:0]      need_reg, need_next;
    logic [CNT_W-1:0]      run_reg, run_next;
    logic [PG_W:0]         first_reg, first_next;
    logic [PG_W-1:0]       last_reg, last_next;
    logic [PG_W-1:0]       fill_idx_reg, fill_idx_next;
    logic [PG_W-1:0]       tag_reg, tag_next;
    logic                  free_first_reg, free_first_next;
    logic [PG_W-1:0]       scan_addr_reg, scan_addr_next;
    logic                  pend_v_reg, pend_v_next;
    logic [PG_W-1:0]       pend_idx_reg, pend_idx_next;
    logic [NUM_PAGES-1:0]  valid_reg, valid_next;
    logic [STATUS_W-1:0]   res_status_reg, res_status_next;
    logic [OFF_W-1:0]      res_offset_reg, res_offset_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    logic [STATUS_W-1:0]   rsp_status_reg, rsp_status_next;
    logic [OFF_W-1:0]      rsp_offset_reg, rsp_offset_next;

    logic                  ram_wr_en;
    logic [ENTRY_W-1:0]    ram_wr_data;
    logic [ENTRY_W-1:0]    ram_rd_data;
    page_entry_t           wr_entry;
    page_entry_t           rd_entry;
    logic                  page_used;
    logic                  last_page;

    logic [SIZE_W:0]       size_sum;
    logic [SIZE_W:0]       need_full;
    logic [SIZE_W-1:0]     off_shifted;
    logic [OFF_W+PG_W+PAGE_SHIFT-1:0] off_wide;

    pra_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_PAGES)
    ) u_page_map (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (fill_idx_reg),
        .wr_data (ram_wr_data),
        .rd_addr (scan_addr_reg),
        .rd_data (ram_rd_data)
    );

    assign req_stall  = (state_reg != S_IDLE);
    assign rsp_valid  = rsp_valid_reg;
    assign status     = rsp_status_reg;
    assign run_offset = rsp_offset_reg;

    assign wr_entry.used      = 1'b1;
    assign wr_entry.run_start = first_reg[PG_W-1:0];
    assign ram_wr_data        = wr_entry;
    assign ram_wr_en          = (state_reg == S_FILL);

    // An entry whose valid bit is clear reads as a free page.
    assign rd_entry  = page_entry_t'(ram_rd_data);
    assign page_used = valid_reg[pend_idx_reg] & rd_entry.used;
    assign last_page = (pend_idx_reg == PG_W'(NUM_PAGES - 1));

    assign size_sum    = {1'b0, size_bytes} + (SIZE_W + 1)'(PAGE_BYTES - 1);
    assign need_full   = size_sum >> PAGE_SHIFT;
    assign off_shifted = free_offset >> PAGE_SHIFT;
    assign off_wide    = {{OFF_W{1'b0}}, first_reg[PG_W-1:0], {PAGE_SHIFT{1'b0}}};

    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        need_next       = need_reg;
        run_next        = run_reg;
        first_next      = first_reg;
        last_next       = last_reg;
        fill_idx_next   = fill_idx_reg;
        tag_next        = tag_reg;
        free_first_next = free_first_reg;
        scan_addr_next  = scan_addr_reg;
        pend_v_next     = 1'b0;
        pend_idx_next   = pend_idx_reg;
        valid_next      = valid_reg;
        res_status_next = res_status_reg;
        res_offset_next = res_offset_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_status_next = rsp_status_reg;
        rsp_offset_next = rsp_offset_reg;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    kind_next       = req_type;
                    res_offset_next = '0;
                    run_next        = '0;
                    first_next      = '0;
                    free_first_next = 1'b1;
                    if (req_type == REQ_ALLOC)
                    begin
                        scan_addr_next = '0;
                        need_next      = CNT_W'(need_full);
                        if (size_bytes == '0)
                        begin
                            res_status_next = STAT_UNSUPPORTED;
                            state_next      = S_RESP;
                        end
                        else if (need_full > (SIZE_W + 1)'(NUM_PAGES))
                        begin
                            res_status_next = STAT_NO_SPACE;
                            state_next      = S_RESP;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    else
                    begin
                        scan_addr_next = off_shifted[PG_W-1:0];
                        if (32'(free_offset) >= POOL_BYTES)
                        begin
                            res_status_next = STAT_RANGE;
                            state_next      = S_RESP;
                        end
                        else if (free_offset[PAGE_SHIFT-1:0] != '0)
                        begin
                            res_status_next = STAT_UNSUPPORTED;
                            state_next      = S_RESP;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                end
            end

            S_SCAN:
            begin
                // One read issued per cycle; the data of the previous address
                // is judged in the same cycle.
                scan_addr_next = scan_addr_reg + 1'b1;
                pend_v_next    = 1'b1;
                pend_idx_next  = scan_addr_reg;
                if (pend_v_reg)
                begin
                    if (kind_reg == REQ_ALLOC)
                    begin
                        if (page_used)
                        begin
                            run_next   = '0;
                            first_next = {1'b0, pend_idx_reg} + 1'b1;
                            if (last_page)
                            begin
                                res_status_next = STAT_NO_SPACE;
                                pend_v_next     = 1'b0;
                                state_next      = S_RESP;
                            end
                        end
                        else
                        begin
                            run_next = run_reg + 1'b1;
                            if (run_reg + 1'b1 == need_reg)
                            begin
                                fill_idx_next = first_reg[PG_W-1:0];
                                last_next     = pend_idx_reg;
                                pend_v_next   = 1'b0;
                                state_next    = S_FILL;
                            end
                            else if (last_page)
                            begin
                                res_status_next = STAT_NO_SPACE;
                                pend_v_next     = 1'b0;
                                state_next      = S_RESP;
                            end
                        end
                    end
                    else
                    begin
                        // The addressed page and the following pages carrying
                        // the same run tag are released.
                        free_first_next = 1'b0;
                        if (page_used && (free_first_reg || rd_entry.run_start == tag_reg))
                        begin
                            if (free_first_reg)
                            begin
                                tag_next = rd_entry.run_start;
                            end
                            valid_next[pend_idx_reg] = 1'b0;
                            if (last_page)
                            begin
                                res_status_next = STAT_OK;
                                pend_v_next     = 1'b0;
                                state_next      = S_RESP;
                            end
                        end
                        else
                        begin
                            res_status_next = STAT_OK;
                            pend_v_next     = 1'b0;
                            state_next      = S_RESP;
                        end
                    end
                end
            end

            S_FILL:
            begin
                valid_next[fill_idx_reg] = 1'b1;
                fill_idx_next            = fill_idx_reg + 1'b1;
                if (fill_idx_reg == last_reg)
                begin
                    res_status_next = STAT_OK;
                    res_offset_next = off_wide[OFF_W-1:0];
                    state_next      = S_RESP;
                end
            end

            S_RESP:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = res_status_reg;
                    rsp_offset_next = res_offset_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pend_v_reg    <= 1'b0;
            valid_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_v_reg    <= pend_v_next;
            valid_reg     <= valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        need_reg       <= need_next;
        run_reg        <= run_next;
        first_reg      <= first_next;
        last_reg       <= last_next;
        fill_idx_reg   <= fill_idx_next;
        tag_reg        <= tag_next;
        free_first_reg <= free_first_next;
        scan_addr_reg  <= scan_addr_next;
        pend_idx_reg   <= pend_idx_next;
        res_status_reg <= res_status_next;
        res_offset_reg <= res_offset_next;
        rsp_status_reg <= rsp_status_next;
        rsp_offset_reg <= rsp_offset_next;
    end

    // Tagging a run only ever claims pages that were free.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FILL) |=>
            ($countones(valid_reg) == $countones($past(valid_reg)) + 1))
        else $error("run fill did not claim exactly one free page");

    // Releasing a run never marks a page as used.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && kind_reg == REQ_FREE) |=>
            ($countones(valid_reg) <= $countones($past(valid_reg))))
        else $error("free scan marked a page as used");

    // An accepted request always takes the engine out of idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> (state_reg != S_IDLE))
        else $error("accepted request left the engine idle");

    // A new response only appears when a finished request hands it over.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_RESP))
        else $error("response raised without a finished request");

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for page_run_allocator: directed and random allocate/free
// beats, a page map predictor and an in-order response checker.
// Depends on pra_pkg and the page_run_allocator RTL only.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pra_pkg::*;

    localparam int GEN_COPY      = 0;
    localparam int CHECK_COPY    = 1;
    localparam int RANDOM_ITEMS  = 700;
    localparam int CALM_TAIL     = 60;
    localparam int HOLD_AFTER    = 100;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 150;
    localparam int STUCK_LIMIT   = 4000;
    localparam int MAX_REPORTS   = 10;
    localparam int FIELD_MAX     = (1 << SIZE_W) - 1;

    typedef struct {
        logic              rtype;
        logic [SIZE_W-1:0] size;
        logic [SIZE_W-1:0] off;
    } req_item_t;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [OFF_W-1:0]    offset;
    } rsp_item_t;

    logic                clk;
    logic                rst_n;
    logic                req_valid;
    logic                req_stall;
    logic                req_type;
    logic [SIZE_W-1:0]   size_bytes;
    logic [SIZE_W-1:0]   free_offset;
    logic                rsp_valid;
    logic                rsp_stall;
    logic [STATUS_W-1:0] status;
    logic [OFF_W-1:0]    run_offset;

    // Two copies of the page map: one steers stimulus generation, one checks.
    page_entry_t pool_map [2][NUM_PAGES];

    req_item_t pending[$];
    rsp_item_t expected_rsp[$];

    logic req_fire;
    int   total_items;
    int   req_taken;
    int   rsp_seen;
    int   err_count;
    int   send_idle;
    int   stall_left;
    int   hold_left;
    bit   held_once;
    int   n_placed, n_no_space, n_freed, n_rejected;

    page_run_allocator DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req_type    (req_type),
        .size_bytes  (size_bytes),
        .free_offset (free_offset),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .status      (status),
        .run_offset  (run_offset)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Works out the response to one request and updates the chosen page map copy.
    function automatic void predict_request(input int c, input logic rtype,
                                            input logic [SIZE_W-1:0] size,
                                            input logic [SIZE_W-1:0] off,
                                            output logic [STATUS_W-1:0] st,
                                            output logic [OFF_W-1:0] ro);
        int need;
        int span;
        int win_start;
        int pg;
        int i;
        logic [PG_W-1:0] tag;
        st = STAT_OK;
        ro = '0;
        if (rtype == REQ_ALLOC)
        begin
            need = (int'(size) + PAGE_BYTES - 1) / PAGE_BYTES;
            if (size == 0)
                st = STAT_UNSUPPORTED;
            else if (need > NUM_PAGES)
                st = STAT_NO_SPACE;
            else
            begin
                span = 0;
                win_start = 0;
                for (i = 0; i < NUM_PAGES && span < need; i++)
                begin
                    if (pool_map[c][i].used)
                    begin
                        span = 0;
                        win_start = i + 1;
                    end
                    else
                        span++;
                end
                if (span != need)
                    st = STAT_NO_SPACE;
                else
                begin
                    for (i = win_start; i < win_start + need; i++)
                    begin
                        pool_map[c][i].used = 1'b1;
                        pool_map[c][i].run_start = PG_W'(win_start);
                    end
                    ro = OFF_W'(win_start * PAGE_BYTES);
                end
            end
        end
        else if (off >= POOL_BYTES)
            st = STAT_RANGE;
        else if (off % PAGE_BYTES != 0)
            st = STAT_UNSUPPORTED;
        else
        begin
            pg = int'(off) / PAGE_BYTES;
            if (pool_map[c][pg].used)
            begin
                // Only the addressed page and later pages of the same run are released.
                tag = pool_map[c][pg].run_start;
                i = pg + 1;
                while (i < NUM_PAGES && pool_map[c][i].used && pool_map[c][i].run_start == tag)
                begin
                    pool_map[c][i] = '0;
                    i++;
                end
                pool_map[c][pg] = '0;
            end
        end
    endfunction

    function automatic void push_req(input logic rtype, input int size, input int off);
        req_item_t it;
        logic [STATUS_W-1:0] st;
        logic [OFF_W-1:0] ro;
        it.rtype = rtype;
        it.size = SIZE_W'(size);
        it.off = SIZE_W'(off);
        pending.push_back(it);
        predict_request(GEN_COPY, it.rtype, it.size, it.off, st, ro);
    endfunction

    task automatic report_mismatch(input string what, input rsp_item_t exp_rsp);
        err_count++;
        if (err_count <= MAX_REPORTS)
        begin
            $write("Mismatch at %0t (%s): expected status %0d offset 0x%05h,",
                   $realtime, what, exp_rsp.status, exp_rsp.offset);
            $display(" got status %0d offset 0x%05h", status, run_offset);
        end
    endtask

    // Request driver: new beats go out at the falling edge once the last one was taken.
    always @(negedge clk)
    begin : drive_req
        req_item_t it;
        if (rst_n && (!req_valid || req_fire))
        begin
            if (send_idle > 0)
            begin
                send_idle--;
                req_valid <= 1'b0;
            end
            else if (pending.size() >= CALM_TAIL && $urandom_range(0, 15) == 0)
            begin
                send_idle = $urandom_range(1, 9) - 1;
                req_valid <= 1'b0;
            end
            else if (pending.size() > 0)
            begin
                it = pending.pop_front();
                req_valid   <= 1'b1;
                req_type    <= it.rtype;
                size_bytes  <= it.size;
                free_offset <= it.off;
            end
            else
                req_valid <= 1'b0;
        end
    end

    // Response stall: short random bursts plus one long hold-off that backs the block up.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else if (!held_once && rsp_seen >= HOLD_AFTER)
            begin
                held_once = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                rsp_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_stall <= 1'b1;
            end
            else if (pending.size() >= CALM_TAIL && $urandom_range(0, 11) == 0)
            begin
                stall_left = $urandom_range(1, 9) - 1;
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    // Monitor: responses are checked before the request of the same edge is predicted.
    always @(posedge clk)
    begin : monitor
        rsp_item_t exp_rsp;
        logic [STATUS_W-1:0] st;
        logic [OFF_W-1:0] ro;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                rsp_seen++;
                if (expected_rsp.size() == 0)
                begin
                    exp_rsp.status = 'x;
                    exp_rsp.offset = 'x;
                    report_mismatch("unexpected beat", exp_rsp);
                end
                else
                begin
                    exp_rsp = expected_rsp.pop_front();
                    if (status !== exp_rsp.status || run_offset !== exp_rsp.offset)
                        report_mismatch("field", exp_rsp);
                end
            end
            if (req_valid && !req_stall)
            begin
                req_taken++;
                predict_request(CHECK_COPY, req_type, size_bytes, free_offset, st, ro);
                exp_rsp.status = st;
                exp_rsp.offset = ro;
                expected_rsp.push_back(exp_rsp);
                if (req_type == REQ_ALLOC && st == STAT_OK)
                    n_placed++;
                else if (st == STAT_NO_SPACE)
                    n_no_space++;
                else if (st == STAT_OK)
                    n_freed++;
                else
                    n_rejected++;
            end
        end
        req_fire <= rst_n && req_valid && !req_stall;
    end

    always @(posedge clk)
    begin : watchdog
        int stuck_cycles;
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("Timeout: no beat moved for %0d cycles, %0d responses outstanding",
                         STUCK_LIMIT, expected_rsp.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        int n;
        int pg;
        int i;
        int k;
        int pages;
        int used_cnt;
        int pick;
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req_type    = REQ_ALLOC;
        size_bytes  = '0;
        free_offset = '0;
        rsp_stall   = 1'b0;
        req_fire    = 1'b0;
        req_taken   = 0;
        rsp_seen    = 0;
        err_count   = 0;
        send_idle   = 0;
        stall_left  = 0;
        hold_left   = 0;
        held_once   = 1'b0;
        n_placed    = 0;
        n_no_space  = 0;
        n_freed     = 0;
        n_rejected  = 0;
        for (pg = 0; pg < NUM_PAGES; pg++)
        begin
            pool_map[GEN_COPY][pg]   = '0;
            pool_map[CHECK_COPY][pg] = '0;
        end

        // Directed opening: rounding, first fit into holes, every reject path,
        // freeing inside a run and a free page, and a run that spans the whole pool.
        push_req(REQ_ALLOC, 0, 0);
        push_req(REQ_ALLOC, 1, FIELD_MAX);
        push_req(REQ_ALLOC, PAGE_BYTES, 0);
        push_req(REQ_ALLOC, PAGE_BYTES + 1, 0);
        push_req(REQ_FREE, 0, PAGE_BYTES);
        push_req(REQ_ALLOC, 2 * PAGE_BYTES, 0);
        push_req(REQ_ALLOC, 4000, 0);
        push_req(REQ_FREE, 0, PAGE_BYTES - 1);
        push_req(REQ_FREE, 0, POOL_BYTES);
        push_req(REQ_FREE, FIELD_MAX, FIELD_MAX);
        push_req(REQ_FREE, 0, POOL_BYTES - PAGE_BYTES);
        push_req(REQ_ALLOC, POOL_BYTES + 1, 0);
        push_req(REQ_ALLOC, FIELD_MAX, 0);
        push_req(REQ_ALLOC, POOL_BYTES, 0);
        push_req(REQ_FREE, 0, 3 * PAGE_BYTES);
        push_req(REQ_FREE, 0, 0);
        push_req(REQ_FREE, 0, PAGE_BYTES);
        push_req(REQ_FREE, 0, 2 * PAGE_BYTES);
        push_req(REQ_FREE, 0, 4 * PAGE_BYTES);
        push_req(REQ_ALLOC, POOL_BYTES, 0);
        push_req(REQ_ALLOC, 1, 0);
        push_req(REQ_FREE, 0, 0);
        push_req(REQ_ALLOC, POOL_BYTES - PAGE_BYTES, 0);
        push_req(REQ_ALLOC, 1, 0);
        push_req(REQ_FREE, 0, 0);

        // Random part: mostly allocations that fit and frees of live runs, with
        // some garbage and malformed requests mixed in.
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            used_cnt = 0;
            for (pg = 0; pg < NUM_PAGES; pg++)
            begin
                if (pool_map[GEN_COPY][pg].used)
                    used_cnt++;
            end
            pick = $urandom_range(0, 99);
            if (pick < 8)
                push_req(1'($urandom_range(0, 1)), $urandom_range(0, FIELD_MAX),
                         $urandom_range(0, FIELD_MAX));
            else if (pick < 10)
                push_req(REQ_ALLOC, 0, $urandom_range(0, FIELD_MAX));
            else if (pick < 12)
                push_req(REQ_FREE, $urandom_range(0, FIELD_MAX),
                         $urandom_range(0, NUM_PAGES - 1) * PAGE_BYTES
                         + $urandom_range(1, PAGE_BYTES - 1));
            else if (used_cnt == 0 || (pick < 56 && used_cnt < 56))
            begin
                pages = ($urandom_range(0, 9) == 0) ? $urandom_range(1, NUM_PAGES)
                                                    : $urandom_range(1, 6);
                push_req(REQ_ALLOC, (pages - 1) * PAGE_BYTES + $urandom_range(1, PAGE_BYTES),
                         $urandom_range(0, FIELD_MAX));
            end
            else
            begin
                k = $urandom_range(1, used_cnt);
                pg = -1;
                for (i = 0; i < NUM_PAGES; i++)
                begin
                    if (pool_map[GEN_COPY][i].used)
                    begin
                        k--;
                        if (k == 0 && pg < 0)
                            pg = i;
                    end
                end
                pick = $urandom_range(0, 9);
                if (pick < 7)
                    pg = pool_map[GEN_COPY][pg].run_start;
                else if (pick == 9)
                    pg = $urandom_range(0, NUM_PAGES - 1);
                push_req(REQ_FREE, $urandom_range(0, FIELD_MAX), pg * PAGE_BYTES);
            end
        end
        total_items = pending.size();

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (req_taken < total_items || expected_rsp.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Ran %0d requests: %0d runs placed, %0d refused for space, %0d frees done,",
                 req_taken, n_placed, n_no_space, n_freed);
        $display("%0d rejected as out of range or unsupported; %0d mismatches found.",
                 n_rejected, err_count);
        if (err_count == 0 && expected_rsp.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
